// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion shorthands used by the date adder core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: sv/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// shared widths, calendar constants and control types for the date adder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gda_pkg;

   localparam int DAY_W        = 5;
   localparam int MONTH_W      = 4;
   localparam int YEAR_W       = 14;
   localparam int COUNT_W      = 16;
   // remaining count may grow by two when the start day lies past month end
   localparam int WALK_W       = COUNT_W + 1;
   localparam int LEFT_W       = 7;

   localparam int YEAR_CYCLE   = 400;
   localparam int CENTURY      = 100;
   localparam int REDUCE_STEPS = 6;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;
   localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;
   localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;
   localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;

   typedef struct packed {
      logic load;
      logic reduce;
      logic bump;
   } yr_ctl_type;

   typedef struct packed {
      logic              leap;
      logic              reduce_done;
      logic [YEAR_W-1:0] rem;
   } yr_stat_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
      logic [DAY_W-1:0] days;
      unique case (month)
         MONTH_FEB: days = leap ? DAYS_FEB_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = DAYS_SHORT;
         default: days = DAYS_LONG;
      endcase
      return days;
   endfunction

endpackage

// File: sv/gda_year_unit.sv
// ----------------------------------------------------------------------------
// gda_year_unit
// year register with its residue mod 400, reduced by shift-subtract after load
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gda_year_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  gda_pkg::yr_ctl_type         ctl,
   input  logic [gda_pkg::YEAR_W-1:0]  load_year,
   output logic [gda_pkg::YEAR_W-1:0]  year,
   output gda_pkg::yr_stat_type        stat
);
   import gda_pkg::*;

   localparam int STEP_W = $clog2(REDUCE_STEPS);

   logic [YEAR_W-1:0] year_ff, year_in;
   logic [YEAR_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [YEAR_W-1:0] cycle_multiple;

   always_comb begin
      cycle_multiple = YEAR_W'(YEAR_CYCLE) << step_ff;
      year_in        = year_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      priority if (ctl.load) begin
         year_in = load_year;
         rem_in  = load_year;
         step_in = STEP_W'(REDUCE_STEPS - 1);
      end else if (ctl.reduce) begin
         if (rem_ff >= cycle_multiple) begin
            rem_in = rem_ff - cycle_multiple;
         end
         if (step_ff != '0) begin
            step_in = step_ff - 1'b1;
         end
      end else if (ctl.bump) begin
         year_in = year_ff + 1'b1;
         // wrap of the year register restarts the 400-year cycle at zero
         if (year_ff == '1 || rem_ff == YEAR_W'(YEAR_CYCLE - 1)) begin
            rem_in = '0;
         end else begin
            rem_in = rem_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      year_ff <= year_in;
      rem_ff  <= rem_in;
   end

   assign year             = year_ff;
   assign stat.rem         = rem_ff;
   assign stat.reduce_done = (step_ff == '0);
   assign stat.leap        = (rem_ff[1:0] == 2'b00)
                             && (rem_ff != YEAR_W'(CENTURY))
                             && (rem_ff != YEAR_W'(2 * CENTURY))
                             && (rem_ff != YEAR_W'(3 * CENTURY));

endmodule

// File: sv/gda_month_step.sv
// ----------------------------------------------------------------------------
// gda_month_step
// one month of the walk: days left, compare with count, advance or finish
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gda_month_step (
   input  logic [gda_pkg::DAY_W-1:0]   day,
   input  logic [gda_pkg::MONTH_W-1:0] month,
   input  logic                        leap,
   input  logic [gda_pkg::WALK_W-1:0]  count,
   output logic [gda_pkg::DAY_W-1:0]   next_day,
   output logic [gda_pkg::MONTH_W-1:0] next_month,
   output logic [gda_pkg::WALK_W-1:0]  next_count,
   output logic                        wrap
);
   import gda_pkg::*;

   logic [DAY_W-1:0]  dim;
   logic [LEFT_W-1:0] left;
   logic              fits;

   always_comb begin
      dim  = month_days(month, leap);
      // days left counting today, zero or negative when the day lies past month end
      left = LEFT_W'(dim) - LEFT_W'(day) + LEFT_W'(1);
      fits = !left[LEFT_W-1] && (count < WALK_W'(left));
      wrap = 1'b0;
      if (fits) begin
         next_day   = day + count[DAY_W-1:0];
         next_month = month;
         next_count = '0;
      end else begin
         next_day   = DAY_W'(1);
         next_count = count - {{(WALK_W-LEFT_W){left[LEFT_W-1]}}, left};
         wrap       = (month == MONTH_DEC);
         next_month = wrap ? MONTH_JAN : month + 1'b1;
      end
   end

endmodule

// File: sv/gregorian_date_add_days_core.sv
// ----------------------------------------------------------------------------
// gregorian_date_add_days_core
// adds a day count to a gregorian date, walking one month per cycle
// ----------------------------------------------------------------------------
// usage
//   req channel carries a start date and a day count; rsp channel returns
//   the date that many days later, one rsp transfer per req transfer
//   req_tready is high only while the core is idle; one item is in work
//   at a time
//   from req transfer to rsp_tvalid an item passes the year reduction mod
//   400, M month steps (one per month boundary crossed plus one for a
//   final partial month), then the output register, which it enters only
//   once that register is free; req_tready rises with rsp_tvalid, so a new
//   req transfer is taken only after the previous item has left the walk
//   a full 65535-day count crosses about 2150 months; the month step unit
//   sets how long such an item takes, being used once per month
//   a finished result sits in the output register; the next req transfer
//   is taken while it waits, and that item's result holds in the walk
//   until rsp_tready frees the register
//   a start month outside 1..12 returns the start date unchanged
//   synchronous active-high reset drops rsp_tvalid and returns to idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gregorian_date_add_days_core (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: start_day[4:0], start_month[8:5], start_year[22:9],
   //            days_to_add[38:23], zero fill[39]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // rsp_tdata: end_day[4:0], end_month[8:5], end_year[22:9], zero fill[23]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata
);
   import gda_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_WALK
   } state_type;

   localparam int RSP_W = 24;

   state_type state_ff;

   // walk registers
   logic [DAY_W-1:0]   day_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [WALK_W-1:0]  count_ff;

   // output register
   logic               rsp_tvalid_ff;
   logic [RSP_W-1:0]   rsp_tdata_ff;

   // unpacked request fields
   logic [DAY_W-1:0]   req_day;
   logic [MONTH_W-1:0] req_month;
   logic [YEAR_W-1:0]  req_year;
   logic [COUNT_W-1:0] req_count;
   logic               req_month_ok;

   logic               req_accept;
   logic               rsp_free;
   logic               rsp_load;
   logic               walk_active;

   yr_ctl_type         yr_ctl;
   yr_stat_type        yr_stat;
   logic [YEAR_W-1:0]  year;

   logic [DAY_W-1:0]   step_day;
   logic [MONTH_W-1:0] step_month;
   logic [WALK_W-1:0]  step_count;
   logic               step_wrap;

   assign req_day   = req_tdata[DAY_W-1:0];
   assign req_month = req_tdata[DAY_W +: MONTH_W];
   assign req_year  = req_tdata[DAY_W+MONTH_W +: YEAR_W];
   assign req_count = req_tdata[DAY_W+MONTH_W+YEAR_W +: COUNT_W];

   // months outside 1..12 skip the walk entirely
   assign req_month_ok = (req_month >= MONTH_JAN) && (req_month <= MONTH_DEC);

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   // output register can take a result this cycle
   assign rsp_free    = !rsp_tvalid_ff || rsp_tready;
   // finished walk moves into the output register
   assign rsp_load    = (state_ff == ST_WALK) && (count_ff == '0) && rsp_free;
   assign walk_active = (state_ff == ST_WALK) && (count_ff != '0);

   always_comb begin
      yr_ctl.load   = req_accept;
      yr_ctl.reduce = (state_ff == ST_REDUCE);
      yr_ctl.bump   = walk_active && step_wrap;
   end

   gda_year_unit u_year (
      .clock     (clock),
      .reset     (reset),
      .ctl       (yr_ctl),
      .load_year (req_year),
      .year      (year),
      .stat      (yr_stat)
   );

   gda_month_step u_step (
      .day        (day_ff),
      .month      (month_ff),
      .leap       (yr_stat.leap),
      .count      (count_ff),
      .next_day   (step_day),
      .next_month (step_month),
      .next_count (step_count),
      .wrap       (step_wrap)
   );

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  day_ff   <= req_day;
                  month_ff <= req_month;
                  count_ff <= req_month_ok ? WALK_W'(req_count) : '0;
                  state_ff <= ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               // year residue settles on the last reduction step
               if (yr_stat.reduce_done) begin
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               if (count_ff != '0) begin
                  day_ff   <= step_day;
                  month_ff <= step_month;
                  count_ff <= step_count;
               end else if (rsp_load) begin
                  rsp_tdata_ff <= {1'b0, year, month_ff, day_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // a new item always starts with the year reduction
   `ASSERT_PROP(a_accept_reduce, clock, reset, req_accept |=> (state_ff == ST_REDUCE), "accepted item did not enter year reduction")

   // month stays in range while the walk is running
   `ASSERT_PROP(a_walk_month, clock, reset, walk_active |-> ((month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC)), "month out of range during walk")

   // year residue is fully reduced before any month step uses it
   `ASSERT_NEVER(a_walk_rem, clock, reset, (state_ff == ST_WALK) && (yr_stat.rem >= YEAR_W'(YEAR_CYCLE)), "year residue not reduced in walk")

endmodule
